// File: sv/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg: shared types and constants
// Fixed-point widths, cell data records, register and status codes for the
// trapezoidal move timing planner.
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    localparam logic [31:0] STEP_RESET  = 32'd655;
    localparam logic [31:0] ACCEL_RESET = 32'd65536;

    typedef enum logic {
        REG_STEP_PERIOD = 1'b0,
        REG_MAX_ACCEL   = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NEG_DISC = 2'd1,
        ST_NO_SOL   = 2'd2
    } status_t;

    // one restoring division step record
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
    } div_t;

    // one square root digit record
    typedef struct packed {
        logic [63:0] x;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    // per-item context that rides along the cell row
    typedef struct packed {
        logic [31:0] mt;
        logic [31:0] d;
        logic [31:0] t;
        logic [63:0] q;
        logic [31:0] n;
        logic [33:0] x3;
        logic [32:0] tacc;
        logic [31:0] tmt;
        logic        e1;
        logic        e2;
    } ctx_t;

endpackage

// File: sv/tpt_if.sv
// ----------------------------------------------------------------------------
// tpt_if: request and response channels
// Valid/ready channels carrying a move request and a planned profile.
// ----------------------------------------------------------------------------
interface tpt_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] move_time;
    logic [31:0] distance;

    modport source (output valid, output move_time, output distance, input ready);
    modport sink   (input valid, input move_time, input distance, output ready);
endinterface

interface tpt_rsp_if;
    logic               valid;
    logic               ready;
    logic        [31:0] accel;
    logic        [31:0] accel_time;
    logic signed [31:0] flat_time;
    logic        [1:0]  status;

    modport source (output valid, output accel, output accel_time, output flat_time,
                    output status, input ready);
    modport sink   (input valid, input accel, input accel_time, input flat_time,
                    input status, output ready);
endinterface

// File: sv/tpt_div_cell.sv
// ----------------------------------------------------------------------------
// tpt_div_cell: one restoring division step
// Brings in one dividend bit, subtracts the divisor when it fits, and passes
// the partial result and the item context to the next cell.
// ----------------------------------------------------------------------------
module tpt_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vin,
    input  tpt_pkg::ctx_t ctx_in,
    input  tpt_pkg::div_t div_in,
    output logic          vout,
    output tpt_pkg::ctx_t ctx_out,
    output tpt_pkg::div_t div_out
);
    import tpt_pkg::*;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;
    div_t        div_next;
    logic        vld_reg;
    ctx_t        ctx_reg;
    div_t        div_reg;

    always_comb
    begin
        trial         = {div_in.rem, div_in.num[63]};
        diff          = trial - {1'b0, div_in.den};
        ge            = (trial >= {1'b0, div_in.den});
        div_next.rem  = ge ? diff[63:0] : trial[63:0];
        div_next.num  = {div_in.num[62:0], 1'b0};
        div_next.den  = div_in.den;
        div_next.quo  = {div_in.quo[62:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg <= ctx_in;
            div_reg <= div_next;
        end
    end

    assign vout    = vld_reg;
    assign ctx_out = ctx_reg;
    assign div_out = div_reg;

endmodule

// File: sv/tpt_div_chain.sv
// ----------------------------------------------------------------------------
// tpt_div_chain: row of division cells
// A 64 by 64 bit restoring divider, one quotient bit per cell.
// ----------------------------------------------------------------------------
module tpt_div_chain (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vin,
    input  tpt_pkg::ctx_t ctx_in,
    input  tpt_pkg::div_t div_in,
    output logic          vout,
    output tpt_pkg::ctx_t ctx_out,
    output tpt_pkg::div_t div_out
);
    import tpt_pkg::*;

    logic vld [0:DIV_STEPS];
    ctx_t ctx [0:DIV_STEPS];
    div_t dv  [0:DIV_STEPS];

    assign vld[0] = vin;
    assign ctx[0] = ctx_in;
    assign dv[0]  = div_in;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        tpt_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vin     (vld[i]),
            .ctx_in  (ctx[i]),
            .div_in  (dv[i]),
            .vout    (vld[i+1]),
            .ctx_out (ctx[i+1]),
            .div_out (dv[i+1])
        );
    end

    assign vout    = vld[DIV_STEPS];
    assign ctx_out = ctx[DIV_STEPS];
    assign div_out = dv[DIV_STEPS];

endmodule

// File: sv/tpt_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tpt_sqrt_cell: one square root digit
// Takes two radicand bits, tries the next root bit, and passes on.
// ----------------------------------------------------------------------------
module tpt_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vin,
    input  tpt_pkg::ctx_t  ctx_in,
    input  tpt_pkg::sqrt_t sq_in,
    output logic           vout,
    output tpt_pkg::ctx_t  ctx_out,
    output tpt_pkg::sqrt_t sq_out
);
    import tpt_pkg::*;

    logic [35:0] cur;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;
    sqrt_t       sq_next;
    logic        vld_reg;
    ctx_t        ctx_reg;
    sqrt_t       sq_reg;

    always_comb
    begin
        cur          = {sq_in.rem, sq_in.x[63:62]};
        trial        = {2'b00, sq_in.root, 2'b01};
        diff         = cur - trial;
        ge           = (cur >= trial);
        sq_next.x    = {sq_in.x[61:0], 2'b00};
        // remainder never exceeds twice the root, so 34 bits hold it
        sq_next.rem  = ge ? diff[33:0] : cur[33:0];
        sq_next.root = {sq_in.root[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg <= ctx_in;
            sq_reg  <= sq_next;
        end
    end

    assign vout    = vld_reg;
    assign ctx_out = ctx_reg;
    assign sq_out  = sq_reg;

endmodule

// File: sv/tpt_sqrt_chain.sv
// ----------------------------------------------------------------------------
// tpt_sqrt_chain: row of square root cells
// Integer square root of a 64 bit radicand, one root bit per cell.
// ----------------------------------------------------------------------------
module tpt_sqrt_chain (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vin,
    input  tpt_pkg::ctx_t  ctx_in,
    input  tpt_pkg::sqrt_t sq_in,
    output logic           vout,
    output tpt_pkg::ctx_t  ctx_out,
    output tpt_pkg::sqrt_t sq_out
);
    import tpt_pkg::*;

    logic  vld [0:SQRT_STEPS];
    ctx_t  ctx [0:SQRT_STEPS];
    sqrt_t sq  [0:SQRT_STEPS];

    assign vld[0] = vin;
    assign ctx[0] = ctx_in;
    assign sq[0]  = sq_in;

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_cell
        tpt_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vin     (vld[i]),
            .ctx_in  (ctx[i]),
            .sq_in   (sq[i]),
            .vout    (vld[i+1]),
            .ctx_out (ctx[i+1]),
            .sq_out  (sq[i+1])
        );
    end

    assign vout    = vld[SQRT_STEPS];
    assign ctx_out = ctx[SQRT_STEPS];
    assign sq_out  = sq[SQRT_STEPS];

endmodule

// File: sv/trapezoid_profile_timing_top.sv
// ----------------------------------------------------------------------------
// trapezoid_profile_timing_top: trapezoidal move timing planner
// Fits step-aligned acceleration and flat times and an acceleration to a
// requested move time and distance.
// ----------------------------------------------------------------------------
// A fully pipelined row of cells that takes one request per clock and returns
// one result per request, in order. It holds four 64-cell restoring dividers
// (step rounding of the move time, 4*d/amax, step rounding of the acceleration
// time, and the final fit of the acceleration) and one 32-cell square root.
// The whole row advances together whenever the output register is empty or
// being taken, so req.ready falls only while a finished result waits on rsp.
// The step period register (0x0) and the acceleration limit register (0x4) are
// written through the APB port; the user must write them only while the planner
// is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module trapezoid_profile_timing_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    tpt_req_if.sink      req,
    tpt_rsp_if.source    rsp
);
    import tpt_pkg::*;

    // configuration registers
    logic [31:0] step_reg;
    logic [31:0] amax_reg;
    reg_idx_t    widx;

    // global advance: the row moves when the output slot is free or being taken
    logic adv;

    // junction signals between the cell rows
    logic  v1_in, v1_out, v2_out, v3_in, v3_out, v4_out;
    logic  vs_in, vs_out;
    ctx_t  c1_in, c1_out, c2_in, c2_out, cs_in, cs_out, c3_in, c3_out, c4_in, c4_out;
    div_t  d1_in, d1_out, d2_in, d2_out, d3_in, d3_out, d4_in, d4_out;
    sqrt_t s_in, s_out;

    // square stage and rounding stages
    logic        vm_reg;
    ctx_t        cm_reg;
    ctx_t        cm_next;
    logic [63:0] prod_reg;
    logic        vp_reg;
    ctx_t        cp_reg;
    ctx_t        cp_next;
    logic        vq_reg;
    ctx_t        cq_reg;
    logic [63:0] den_reg;

    // output slot
    logic               ov_reg;
    logic        [31:0] accel_reg;
    logic        [31:0] atime_reg;
    logic signed [31:0] flat_reg;
    status_t            status_reg;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            amax_reg <= ACCEL_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (widx)
                REG_STEP_PERIOD: step_reg <= pwdata;
                REG_MAX_ACCEL:   amax_reg <= pwdata;
                default:         step_reg <= step_reg;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_STEP_PERIOD: prdata = step_reg;
            REG_MAX_ACCEL:   prdata = amax_reg;
            default:         prdata = 32'd0;
        endcase
    end

    assign adv       = !ov_reg || rsp.ready;
    assign req.ready = adv;

    // row 1: remainder of (mt + step - 1) / step for step rounding
    always_comb
    begin
        v1_in     = req.valid;
        c1_in     = '0;
        c1_in.mt  = req.move_time;
        c1_in.d   = req.distance;
        d1_in     = '0;
        d1_in.num = 64'({1'b0, req.move_time} + {1'b0, step_reg} - 33'd1);
        d1_in.den = 64'(step_reg);
    end

    tpt_div_chain u_div_time (
        .clk (clk), .rst_n (rst_n), .en (adv),
        .vin (v1_in), .ctx_in (c1_in), .div_in (d1_in),
        .vout (v1_out), .ctx_out (c1_out), .div_out (d1_out)
    );

    // step-aligned move time, saturated to 32 bits; row 2: Q = 4*d*2^F / amax
    logic [32:0] x1;
    logic [32:0] t33;
    always_comb
    begin
        x1  = {1'b0, c1_out.mt} + {1'b0, step_reg} - 33'd1;
        t33 = (step_reg == 32'd0) ? {1'b0, c1_out.mt} : (x1 - {1'b0, d1_out.rem[31:0]});
        c2_in      = c1_out;
        c2_in.t    = t33[32] ? 32'hFFFF_FFFF : t33[31:0];
        c2_in.e1   = (amax_reg == 32'd0) && (c1_out.d != 32'd0);
        d2_in      = '0;
        d2_in.num  = 64'(c1_out.d) << (FRAC_BITS + 2);
        d2_in.den  = 64'(amax_reg);
    end

    tpt_div_chain u_div_disc (
        .clk (clk), .rst_n (rst_n), .en (adv),
        .vin (v1_out), .ctx_in (c2_in), .div_in (d2_in),
        .vout (v2_out), .ctx_out (c2_out), .div_out (d2_out)
    );

    // square of the move time
    always_comb
    begin
        cm_next   = c2_out;
        cm_next.q = (amax_reg == 32'd0) ? 64'd0 : d2_out.quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else if (adv)
        begin
            vm_reg <= v2_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cm_reg   <= cm_next;
            prod_reg <= 64'(c2_out.t) * 64'(c2_out.t);
        end
    end

    // discriminant and square root radicand
    logic [63:0] t2;
    logic [63:0] disc;
    always_comb
    begin
        t2        = prod_reg >> FRAC_BITS;
        disc      = t2 - cm_reg.q;
        vs_in     = vm_reg;
        cs_in     = cm_reg;
        cs_in.e1  = cm_reg.e1 || (t2 < cm_reg.q);
        s_in      = '0;
        s_in.x    = disc << FRAC_BITS;
    end

    tpt_sqrt_chain u_sqrt (
        .clk (clk), .rst_n (rst_n), .en (adv),
        .vin (vs_in), .ctx_in (cs_in), .sq_in (s_in),
        .vout (vs_out), .ctx_out (cs_out), .sq_out (s_out)
    );

    // smaller root; row 3: remainder for rounding (T-s)/2 up to a step
    always_comb
    begin
        v3_in      = vs_out;
        c3_in      = cs_out;
        c3_in.e2   = (s_out.root == 32'd0) || (s_out.root >= cs_out.t);
        c3_in.n    = cs_out.t - s_out.root;
        c3_in.x3   = {2'b00, c3_in.n} + {1'b0, step_reg, 1'b0} - 34'd1;
        d3_in      = '0;
        d3_in.num  = 64'(c3_in.x3);
        d3_in.den  = 64'({step_reg, 1'b0});
    end

    tpt_div_chain u_div_accel_time (
        .clk (clk), .rst_n (rst_n), .en (adv),
        .vin (v3_in), .ctx_in (c3_in), .div_in (d3_in),
        .vout (v3_out), .ctx_out (c3_out), .div_out (d3_out)
    );

    // acceleration time: multiple of 2*step is even, so halving is exact
    logic [33:0] xr;
    logic [32:0] n1;
    logic [32:0] tacc;
    always_comb
    begin
        xr   = c3_out.x3 - d3_out.rem[33:0];
        n1   = {1'b0, c3_out.n} + 33'd1;
        tacc = (step_reg == 32'd0) ? {1'b0, n1[32:1]} : xr[33:1];
    end

    always_comb
    begin
        cp_next      = c3_out;
        cp_next.tacc = tacc;
        cp_next.tmt  = c3_out.t - tacc[31:0];
        cp_next.e2   = c3_out.e2 || (tacc >= {1'b0, c3_out.t});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            vq_reg <= 1'b0;
        end
        else if (adv)
        begin
            vp_reg <= v3_out;
            vq_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cp_reg  <= cp_next;
            cq_reg  <= cp_reg;
            den_reg <= 64'(cp_reg.tacc[31:0]) * 64'(cp_reg.tmt);
        end
    end

    // row 4: accel = d * 2^(2F) / (tacc * (T - tacc))
    always_comb
    begin
        c4_in     = cq_reg;
        c4_in.e2  = cq_reg.e2 || (den_reg == 64'd0);
        d4_in     = '0;
        d4_in.num = 64'(cq_reg.d) << (2 * FRAC_BITS);
        d4_in.den = den_reg;
    end

    tpt_div_chain u_div_accel (
        .clk (clk), .rst_n (rst_n), .en (adv),
        .vin (vq_reg), .ctx_in (c4_in), .div_in (d4_in),
        .vout (v4_out), .ctx_out (c4_out), .div_out (d4_out)
    );

    // flat time, saturated to the signed 32 bit range
    logic signed [34:0] flat_w;
    logic signed [31:0] flat_sat;
    always_comb
    begin
        flat_w = $signed({3'b000, c4_out.t}) - $signed({1'b0, c4_out.tacc, 1'b0});
        if (flat_w > 35'sd2147483647)
        begin
            flat_sat = 32'sh7FFF_FFFF;
        end
        else if (flat_w < -35'sd2147483648)
        begin
            flat_sat = 32'sh8000_0000;
        end
        else
        begin
            flat_sat = flat_w[31:0];
        end
    end

    // output slot; an error zeroes every timing field
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= v4_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (c4_out.e1)
            begin
                status_reg <= ST_NEG_DISC;
                accel_reg  <= 32'd0;
                atime_reg  <= 32'd0;
                flat_reg   <= 32'sd0;
            end
            else if (c4_out.e2)
            begin
                status_reg <= ST_NO_SOL;
                accel_reg  <= 32'd0;
                atime_reg  <= 32'd0;
                flat_reg   <= 32'sd0;
            end
            else
            begin
                status_reg <= ST_OK;
                accel_reg  <= (d4_out.quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : d4_out.quo[31:0];
                atime_reg  <= c4_out.tacc[31:0];
                flat_reg   <= flat_sat;
            end
        end
    end

    assign rsp.valid      = ov_reg;
    assign rsp.accel      = accel_reg;
    assign rsp.accel_time = atime_reg;
    assign rsp.flat_time  = flat_reg;
    assign rsp.status     = status_reg;

    // an error beat carries all-zero timing
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && (status_reg != ST_OK)) |->
        (accel_reg == 32'd0 && atime_reg == 32'd0 && flat_reg == 32'sd0))
        else $error("error beat with nonzero timing");

    // a good plan always has a nonzero acceleration phase
    a_ok_tacc: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && (status_reg == ST_OK)) |-> (atime_reg != 32'd0))
        else $error("good plan with zero acceleration time");

    // requests stall only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (rsp.valid && !rsp.ready))
        else $error("request stalled without a waiting result");

endmodule
